// ===== rtl/glmd_pkg.sv =====
package glmd_pkg;

  // Defaults for the top-level size parameters
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  // Fixed field widths
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned HEIGHT_W = 4;
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned ENTRY_W  = 2 * HEIGHT_W;

  // Tallest height kept; larger inputs saturate here
  localparam logic [HEIGHT_W-1:0] HEIGHT_SAT = 4'd9;

  // Words buffered between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_ROW_WIDTH = 1'b0,
    REG_ROW_COUNT = 1'b1
  } cfg_reg_t;

  // Position classification, computed at accept time
  typedef struct packed {
    logic y_gt0;
    logic y_gt1;
    logic last_row;
    logic x_gt0;
    logic x_gt1;
    logic row_end;
  } pos_flags_t;

  // One verdict before the run_last tag is attached
  typedef struct packed {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [HEIGHT_W-1:0] level;
    logic                is_low;
    logic                frame_last;
  } verdict_t;

  // Strictly below a neighbor, or the neighbor lies outside the frame
  function automatic logic below(input logic [HEIGHT_W-1:0] c,
                                 input logic [HEIGHT_W-1:0] nb,
                                 input logic                present);
    return !present || (c < nb);
  endfunction

endpackage

// ===== rtl/grid_local_minimum_detect.sv =====
// Four-neighbor low point detector for a raster height map.
// Input channel: one height per word (in_valid/in_ready), raster order,
// column 0 first. Heights above 9 are clamped to 9.
// Result channel: one verdict per word (out_valid/out_ready). Pixel (x,y)
// brings the verdict for (x,y-1); on the last row it also brings the verdict
// for (x-1,y) and, at row end, for (x,y), so a word yields zero to three
// verdicts. out_run_last marks the last verdict of a word, out_frame_last
// the verdict for the final pixel of the frame.
// Configuration: cfg_we with cfg_index (0 row_width, 1 row_count) and
// cfg_wdata; zero reads as 1, oversize clamps to the maximum, and every
// write restarts the frame at (0,0). Write only while the block is idle.
// A taken word passes the queue and the evaluation stage to the output register.
// Throughput: one word per cycle while each word gives at most one verdict and
// out_ready is high; the output register passes one verdict per cycle, so a
// last-row word that gives two or three verdicts holds the evaluation stage.
// A four-word queue separates the input from the evaluation stage, so a
// stalled receiver backs up the queue before in_ready drops.
// Reset: frame size 256 x 256 (clamped to the maximums), position (0,0).
// Line memory content is not cleared and needs no init pass.
module grid_local_minimum_detect
  import glmd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [HEIGHT_W-1:0] in_height,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  out_col,
  output logic [COORD_W-1:0]  out_row,
  output logic [HEIGHT_W-1:0] out_level,
  output logic                out_is_low,
  output logic                out_run_last,
  output logic                out_frame_last
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned QW = HEIGHT_W + XW + COORD_W + $bits(pos_flags_t);

  logic                q_full, push, q_valid, q_pop;
  logic [HEIGHT_W-1:0] push_h, q_h;
  logic [XW-1:0]       push_x, q_x;
  logic [COORD_W-1:0]  push_y, q_y;
  pos_flags_t          push_f, q_f;
  logic [QW-1:0]       q_in, q_out;

  logic                rd_en, wr_en;
  logic [XW-1:0]       rd_addr0, rd_addr1, wr_addr;
  logic [ENTRY_W-1:0]  rd_ent0, rd_ent1, wr_data;

  // Front: config, raster position, classification
  glmd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .XW        (XW),
    .YW        (YW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_height(in_height),
    .q_full   (q_full),
    .push     (push),
    .push_h   (push_h),
    .push_x   (push_x),
    .push_y   (push_y),
    .push_f   (push_f)
  );

  assign q_in = {push_h, push_x, push_y, push_f};
  assign {q_h, q_x, q_y, q_f} = q_out;

  glmd_fifo #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_out)
  );

  glmd_linemem #(
    .DEPTH(MAX_WIDTH),
    .AW   (XW)
  ) u_linemem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .rd_data0(rd_ent0),
    .rd_data1(rd_ent1),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Back: neighbor compare and verdict sequencing
  glmd_back #(
    .XW(XW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_h           (q_h),
    .q_x           (q_x),
    .q_y           (q_y),
    .q_f           (q_f),
    .q_pop         (q_pop),
    .rd_en         (rd_en),
    .rd_addr0      (rd_addr0),
    .rd_addr1      (rd_addr1),
    .rd_ent0       (rd_ent0),
    .rd_ent1       (rd_ent1),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_level     (out_level),
    .out_is_low    (out_is_low),
    .out_run_last  (out_run_last),
    .out_frame_last(out_frame_last)
  );

  // The frame-end verdict is always the last one of its word
  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_run_last)
    else $error("frame_last verdict not tagged run_last");

  // Saturation keeps every reported level in range
  a_level_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= HEIGHT_SAT)
    else $error("reported level above saturation");

  // A low point at the top level has no neighbors, only a 1x1 frame allows it
  a_top_level_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_low && out_level == HEIGHT_SAT |-> out_frame_last)
    else $error("low point at saturated level outside a single-pixel frame");

endmodule

// ===== rtl/glmd_fifo.sv =====
module glmd_fifo
  import glmd_pkg::*;
#(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/glmd_linemem.sv =====
module glmd_linemem
  import glmd_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_WIDTH,
  parameter int unsigned AW    = $clog2(DEF_MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr0,
  input  logic [AW-1:0]      rd_addr1,
  output logic [ENTRY_W-1:0] rd_data0,
  output logic [ENTRY_W-1:0] rd_data1,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data
);

  // Each entry holds one column: newest row in the upper nibble
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data0_r, rd_data1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered reads; a same-edge write to the read column is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0_r <= (wr_en && wr_addr == rd_addr0) ? wr_data : mem[rd_addr0];
      rd_data1_r <= (wr_en && wr_addr == rd_addr1) ? wr_data : mem[rd_addr1];
    end
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

// ===== rtl/glmd_front.sv =====
module glmd_front
  import glmd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned XW         = $clog2(DEF_MAX_WIDTH),
  parameter int unsigned YW         = $clog2(DEF_MAX_HEIGHT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [HEIGHT_W-1:0] in_height,
  input  logic                q_full,
  output logic                push,
  output logic [HEIGHT_W-1:0] push_h,
  output logic [XW-1:0]       push_x,
  output logic [COORD_W-1:0]  push_y,
  output pos_flags_t          push_f
);

  localparam int unsigned W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH - 1 : 255;
  localparam int unsigned H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT - 1 : 255;

  // Frame size kept as last column and last row index
  logic [XW-1:0] wm1_r, wm1_nxt;
  logic [YW-1:0] hm1_r, hm1_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;

  function automatic logic [XW-1:0] clamp_w(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      return XW'(MAX_WIDTH - 1);
    end else begin
      return XW'(v - 9'd1);
    end
  endfunction

  function automatic logic [YW-1:0] clamp_h(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (32'(v) > 32'(MAX_HEIGHT)) begin
      return YW'(MAX_HEIGHT - 1);
    end else begin
      return YW'(v - 9'd1);
    end
  endfunction

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign push_h   = (in_height > HEIGHT_SAT) ? HEIGHT_SAT : in_height;
  assign push_x   = x_r;
  assign push_y   = COORD_W'(y_r);

  // Classify the position of the arriving pixel
  always_comb begin
    push_f.y_gt0    = (y_r != '0);
    push_f.y_gt1    = (y_r > YW'(1));
    push_f.last_row = (y_r == hm1_r);
    push_f.x_gt0    = (x_r != '0);
    push_f.x_gt1    = (x_r > XW'(1));
    push_f.row_end  = (x_r == wm1_r);
  end

  // Raster position and configuration; a register write restarts the frame
  always_comb begin
    wm1_nxt = wm1_r;
    hm1_nxt = hm1_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH: wm1_nxt = clamp_w(cfg_wdata);
        REG_ROW_COUNT: hm1_nxt = clamp_h(cfg_wdata);
        default:       wm1_nxt = wm1_r;
      endcase
      x_nxt = '0;
      y_nxt = '0;
    end else if (push) begin
      if (push_f.row_end) begin
        x_nxt = '0;
        y_nxt = push_f.last_row ? '0 : y_r + YW'(1);
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r <= XW'(W_RST);
      hm1_r <= YW'(H_RST);
      x_r   <= '0;
      y_r   <= '0;
    end else begin
      wm1_r <= wm1_nxt;
      hm1_r <= hm1_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
    end
  end

endmodule

// ===== rtl/glmd_back.sv =====
module glmd_back
  import glmd_pkg::*;
#(
  parameter int unsigned XW = $clog2(DEF_MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  // queue head
  input  logic                q_valid,
  input  logic [HEIGHT_W-1:0] q_h,
  input  logic [XW-1:0]       q_x,
  input  logic [COORD_W-1:0]  q_y,
  input  pos_flags_t          q_f,
  output logic                q_pop,
  // line memory
  output logic                rd_en,
  output logic [XW-1:0]       rd_addr0,
  output logic [XW-1:0]       rd_addr1,
  input  logic [ENTRY_W-1:0]  rd_ent0,
  input  logic [ENTRY_W-1:0]  rd_ent1,
  output logic                wr_en,
  output logic [XW-1:0]       wr_addr,
  output logic [ENTRY_W-1:0]  wr_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  out_col,
  output logic [COORD_W-1:0]  out_row,
  output logic [HEIGHT_W-1:0] out_level,
  output logic                out_is_low,
  output logic                out_run_last,
  output logic                out_frame_last
);

  // Pixel under evaluation
  logic                s2_valid_r, s2_valid_nxt;
  logic [HEIGHT_W-1:0] s2_h_r;
  logic [XW-1:0]       s2_x_r;
  logic [COORD_W-1:0]  s2_y_r;
  pos_flags_t          s2_f_r;
  logic [2:0]          sent_r, sent_nxt;

  // Same-row history: last two heights, and the row above the last pixel
  logic [HEIGHT_W-1:0] h1_r, h2_r, pl_r;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  verdict_t            out_v_r;
  logic                out_last_r;

  logic [HEIGHT_W-1:0] up_c, up_up, up_rt;
  verdict_t            v_a, v_b, v_c, v_sel;
  logic [2:0]          mask, rem, pick;
  logic                rem_last, out_load, emit, s2_fire;

  assign up_c  = rd_ent0[ENTRY_W-1:HEIGHT_W];
  assign up_up = rd_ent0[HEIGHT_W-1:0];
  assign up_rt = rd_ent1[ENTRY_W-1:HEIGHT_W];

  // Verdict for the pixel one row up
  always_comb begin
    v_a.col        = COORD_W'(s2_x_r);
    v_a.row        = s2_y_r - COORD_W'(1);
    v_a.level      = up_c;
    v_a.is_low     = below(up_c, up_up, s2_f_r.y_gt1) && below(up_c, s2_h_r, 1'b1) &&
                     below(up_c, pl_r, s2_f_r.x_gt0) && below(up_c, up_rt, !s2_f_r.row_end);
    v_a.frame_last = 1'b0;
  end

  // Verdict for the left pixel on the last row
  always_comb begin
    v_b.col        = COORD_W'(s2_x_r) - COORD_W'(1);
    v_b.row        = s2_y_r;
    v_b.level      = h1_r;
    v_b.is_low     = below(h1_r, pl_r, s2_f_r.y_gt0) && below(h1_r, h2_r, s2_f_r.x_gt1) &&
                     below(h1_r, s2_h_r, 1'b1);
    v_b.frame_last = 1'b0;
  end

  // Verdict for the final pixel of the frame
  always_comb begin
    v_c.col        = COORD_W'(s2_x_r);
    v_c.row        = s2_y_r;
    v_c.level      = s2_h_r;
    v_c.is_low     = below(s2_h_r, up_c, s2_f_r.y_gt0) && below(s2_h_r, h1_r, s2_f_r.x_gt0);
    v_c.frame_last = 1'b1;
  end

  // Results still owed by this pixel, oldest first
  assign mask[0] = s2_f_r.y_gt0;
  assign mask[1] = s2_f_r.last_row && s2_f_r.x_gt0;
  assign mask[2] = s2_f_r.last_row && s2_f_r.row_end;
  assign rem     = mask & ~sent_r;

  always_comb begin
    if (rem[0]) begin
      pick  = 3'b001;
      v_sel = v_a;
    end else if (rem[1]) begin
      pick  = 3'b010;
      v_sel = v_b;
    end else begin
      pick  = 3'b100;
      v_sel = v_c;
    end
  end

  assign rem_last = ((rem & ~pick) == 3'b000);
  assign out_load = !out_valid_r || out_ready;
  assign emit     = s2_valid_r && (rem != 3'b000) && out_load;
  assign s2_fire  = s2_valid_r && ((rem == 3'b000) || (emit && rem_last));
  assign q_pop    = q_valid && (!s2_valid_r || s2_fire);

  // Memory: read the column and its right neighbor on pop, write back on retire
  assign rd_en    = q_pop;
  assign rd_addr0 = q_x;
  assign rd_addr1 = q_x + XW'(1);
  assign wr_en    = s2_fire;
  assign wr_addr  = s2_x_r;
  assign wr_data  = {s2_h_r, up_c};

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    sent_nxt     = sent_r;
    if (emit) begin
      sent_nxt = sent_r | pick;
    end
    if (s2_fire) begin
      s2_valid_nxt = 1'b0;
      sent_nxt     = 3'b000;
    end
    if (q_pop) begin
      s2_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      sent_r      <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_h_r <= q_h;
      s2_x_r <= q_x;
      s2_y_r <= q_y;
      s2_f_r <= q_f;
    end
    if (s2_fire) begin
      h2_r <= h1_r;
      h1_r <= s2_h_r;
      pl_r <= up_c;
    end
    if (emit) begin
      out_v_r    <= v_sel;
      out_last_r <= rem_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_col        = out_v_r.col;
  assign out_row        = out_v_r.row;
  assign out_level      = out_v_r.level;
  assign out_is_low     = out_v_r.is_low;
  assign out_run_last   = out_last_r;
  assign out_frame_last = out_v_r.frame_last;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import glmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the block empty its queue when the last words gave no verdict
  localparam int unsigned DRAIN_CYCLES = 12;
  // Long receiver hold-off, enough to fill the internal queue and stall in_ready
  localparam int unsigned HOLD_CYCLES  = 150;
  // Stands in for a neighbor outside the frame: above every height
  localparam int unsigned NO_NEIGHBOR  = 16;
  // Words to send over the whole run
  localparam int unsigned TOTAL_WORDS  = 260;

  typedef struct packed {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [HEIGHT_W-1:0] level;
    logic                is_low;
    logic                run_last;
    logic                frame_last;
  } low_verdict_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_index = REG_ROW_WIDTH;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [HEIGHT_W-1:0] in_height = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COORD_W-1:0]  out_col;
  logic [COORD_W-1:0]  out_row;
  logic [HEIGHT_W-1:0] out_level;
  logic                out_is_low;
  logic                out_run_last;
  logic                out_frame_last;

  grid_local_minimum_detect u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_height      (in_height),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_level      (out_level),
    .out_is_low     (out_is_low),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Heights waiting to be sent, verdicts waiting to come back
  logic [HEIGHT_W-1:0] pending_heights [$];
  low_verdict_t        verdicts_due [$];
  int unsigned         mismatch_count = 0;
  int unsigned         queued_words   = 0;

  // Idling controls, set per phase by the stimulus process
  int unsigned feed_gap_max   = 0;
  int unsigned sink_stall_max = 0;
  int unsigned holds_asked    = 0;

  // Predictor state: two line rows in ping-pong, frame position and size
  logic [HEIGHT_W-1:0] line_mem [2][DEF_MAX_WIDTH];
  logic                prev_bank = 1'b0;
  int unsigned         pos_x = 0;
  int unsigned         pos_y = 0;
  int unsigned         frame_w = DEF_MAX_WIDTH;
  int unsigned         frame_h = DEF_MAX_HEIGHT;

  // Appends one height to the send list
  function automatic void queue_height(input logic [HEIGHT_W-1:0] hv);
    pending_heights.insert(pending_heights.size(), hv);
    queued_words++;
  endfunction

  function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  // A register write sets the size and restarts the frame at (0,0)
  function automatic void load_reg(input logic [0:0] idx, input logic [CFG_W-1:0] v);
    if (idx == REG_ROW_WIDTH) frame_w = fit_dim(v, DEF_MAX_WIDTH);
    else frame_h = fit_dim(v, DEF_MAX_HEIGHT);
    pos_x = 0;
    pos_y = 0;
  endfunction

  function automatic low_verdict_t make_verdict(input int unsigned x, input int unsigned y,
                                                input int unsigned c, input int unsigned up,
                                                input int unsigned dn, input int unsigned lf,
                                                input int unsigned rt, input logic fl);
    low_verdict_t v;
    v.col        = COORD_W'(x);
    v.row        = COORD_W'(y);
    v.level      = HEIGHT_W'(c);
    v.is_low     = (c < up) && (c < dn) && (c < lf) && (c < rt);
    v.run_last   = 1'b0;
    v.frame_last = fl;
    return v;
  endfunction

  // Verdicts released by one accepted height word, in output order
  function automatic void judge_pixel(input logic [HEIGHT_W-1:0] raw);
    low_verdict_t v [3];
    int unsigned  n, x, y, h, prv, cur, up, lf, rt;
    n   = 0;
    x   = pos_x;
    y   = pos_y;
    prv = 32'(prev_bank);
    cur = prv ^ 32'd1;
    h   = (raw > HEIGHT_SAT) ? 32'(HEIGHT_SAT) : 32'(raw);

    // pixel above is now complete
    if (y > 0) begin
      up = (y > 1) ? 32'(line_mem[cur][x]) : NO_NEIGHBOR;
      lf = (x > 0) ? 32'(line_mem[prv][x-1]) : NO_NEIGHBOR;
      rt = (x + 1 < frame_w) ? 32'(line_mem[prv][x+1]) : NO_NEIGHBOR;
      v[n] = make_verdict(x, y - 1, 32'(line_mem[prv][x]), up, h, lf, rt, 1'b0);
      n++;
    end

    line_mem[cur][x] = HEIGHT_W'(h);

    // last row: left pixel now has its right neighbor; row end closes this one
    if (y + 1 >= frame_h) begin
      if (x > 0) begin
        up = (y > 0) ? 32'(line_mem[prv][x-1]) : NO_NEIGHBOR;
        lf = (x > 1) ? 32'(line_mem[cur][x-2]) : NO_NEIGHBOR;
        v[n] = make_verdict(x - 1, y, 32'(line_mem[cur][x-1]), up, NO_NEIGHBOR, lf, h, 1'b0);
        n++;
      end
      if (x + 1 >= frame_w) begin
        up = (y > 0) ? 32'(line_mem[prv][x]) : NO_NEIGHBOR;
        lf = (x > 0) ? 32'(line_mem[cur][x-1]) : NO_NEIGHBOR;
        v[n] = make_verdict(x, y, h, up, NO_NEIGHBOR, lf, NO_NEIGHBOR, 1'b1);
        n++;
      end
    end

    for (int i = 0; i < n; i++) begin
      v[i].run_last = (i == n - 1);
      verdicts_due.insert(verdicts_due.size(), v[i]);
    end

    // advance position, swap rows at row end, wrap at frame end
    if (x + 1 >= frame_w) begin
      pos_x     = 0;
      prev_bank = cur[0];
      pos_y     = (y + 1 >= frame_h) ? 0 : y + 1;
    end else begin
      pos_x = x + 1;
    end
  endfunction

  // Input side: sends queued heights, random gap between words
  int unsigned feed_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (cfg_we) load_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) judge_pixel(in_height);
      if (!in_valid || in_ready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (pending_heights.size() > 0) begin
          in_valid  <= 1'b1;
          in_height <= pending_heights.pop_front();
          feed_gap = $urandom_range(0, feed_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Output side: checks each verdict word, random stalls plus a rare long hold
  low_verdict_t head_verdict;
  int unsigned  sink_stall  = 0;
  int unsigned  hold_left   = 0;
  int unsigned  holds_done  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict with none due: col %0d row %0d", out_col, out_row);
          mismatch_count++;
        end else begin
          head_verdict = verdicts_due.pop_front();
          check_field("col", head_verdict.col, out_col);
          check_field("row", head_verdict.row, out_row);
          check_field("level", head_verdict.level, out_level);
          check_field("is_low", head_verdict.is_low, out_is_low);
          check_field("run_last", head_verdict.run_last, out_run_last);
          check_field("frame_last", head_verdict.frame_last, out_frame_last);
        end
        sink_stall = $urandom_range(0, sink_stall_max);
      end
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    write_reg(REG_ROW_WIDTH, w);
    write_reg(REG_ROW_COUNT, h);
  endtask

  // Heights packed one per nibble, first word in the top nibble
  function automatic void queue_nibbles(input logic [99:0] hs, input int count);
    for (int i = count - 1; i >= 0; i--) queue_height(hs[4*i +: 4]);
  endfunction

  // Mostly legal digits, some oversize values to hit saturation
  function automatic void queue_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15) queue_height(HEIGHT_W'($urandom_range(10, 15)));
      else queue_height(HEIGHT_W'($urandom_range(0, 9)));
    end
  endfunction

  // Wait until every word is sent and every verdict is back, then let the block empty
  task automatic settle();
    do @(negedge clk);
    while (pending_heights.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Stimulus sequence
  int unsigned rw, rh, nw;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    feed_gap_max   = 17;
    sink_stall_max = 17;

    // reset size 256 x 256: part of row 0, nothing judged yet
    queue_nibbles(16'h9_0_F_7, 4);
    settle();

    // 3 x 3: interior low, corner lows, ties, saturated heights
    set_frame(3, 3);
    queue_nibbles(36'h5_9_0_F_5_A_0_9_9, 9);
    settle();

    // zero sizes read as one: single pixel frames
    set_frame(0, 0);
    queue_nibbles(8'h9_3, 2);
    settle();

    // single row
    feed_gap_max   = 0;
    sink_stall_max = 0;
    set_frame(4, 1);
    queue_nibbles(16'h2_2_1_7, 4);
    settle();

    // single column
    feed_gap_max   = 17;
    set_frame(1, 3);
    queue_nibbles(12'h4_2_6, 3);
    settle();

    // frame cut short by the next register write
    sink_stall_max = 17;
    set_frame(2, 2);
    queue_nibbles(12'h1_3_0, 3);
    settle();

    // oversize width clamps to the widest row; single row, first part only
    feed_gap_max   = 3;
    sink_stall_max = 3;
    set_frame(511, 1);
    queue_random(30);
    settle();

    // tallest frame, one column, first rows only
    set_frame(1, 256);
    queue_random(30);
    settle();

    // back-to-back sender against a long receiver hold-off
    feed_gap_max   = 0;
    sink_stall_max = 0;
    set_frame(8, 8);
    holds_asked++;
    queue_random(64);
    settle();

    // random phases, mostly small frames
    while (queued_words < TOTAL_WORDS) begin
      feed_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 17;
      sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
      rw = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      rh = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) rw = 0;
      if ($urandom_range(0, 9) == 0) rh = 0;
      case ($urandom_range(0, 4))
        0: ;  // keep going from where the last phase stopped
        1: write_reg(REG_ROW_WIDTH, rw);
        2: write_reg(REG_ROW_COUNT, rh);
        default: set_frame(rw, rh);
      endcase
      nw = $urandom_range(1, 40);
      queue_random(nw);
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && verdicts_due.size() == 0) begin
      $display("grid_local_minimum_detect verification clean");
    end else begin
      $display("grid_local_minimum_detect verification failed");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("grid_local_minimum_detect verification failed");
    $finish;
  end

endmodule
